FILE: sv/velocity_key_matrix_scanner_core_macros.svh
// Assertion macros for the key matrix scanner checks.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef VELOCITY_KEY_MATRIX_SCANNER_CORE_MACROS_SVH
`define VELOCITY_KEY_MATRIX_SCANNER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define VKMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define VKMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/vkms_pkg.sv
package vkms_pkg;

    // Field widths
    localparam int ROW_PORT_W = 16;
    localparam int TIME_W     = 20;
    localparam int STAMP_W    = 32;
    localparam int VEL_W      = 7;
    localparam int NOTE_W     = 8;
    localparam int DIV_W      = TIME_W + 6;
    localparam int REM_W      = TIME_W + 7;

    // Item opcodes
    localparam logic OP_SCAN   = 1'b0;
    localparam logic OP_BUTTON = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_FAST_GAP  = 2'd0;
    localparam logic [1:0] REG_SLOW_GAP  = 2'd1;
    localparam logic [1:0] REG_BASE_NOTE = 2'd2;

    // Message status codes
    localparam logic [7:0] STATUS_NOTE_ON  = 8'd144;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'd128;

    localparam logic [VEL_W-1:0] FULL_VELOCITY = 7'd127;

    // Octave shift limits
    localparam logic signed [2:0] OCT_LOW  = -3'sd3;
    localparam logic signed [2:0] OCT_HIGH = 3'sd3;

    // Shared control from the sequencer to every lane
    typedef struct packed {
        logic              load;
        logic              mul_en;
        logic              div_en;
        logic              sq_en;
        logic              cube_en;
        logic              bad_window;
        logic [TIME_W-1:0] fast_gap;
        logic [TIME_W-1:0] slow_gap;
        logic [DIV_W-1:0]  divisor;
    } vkms_ctrl_t;

    // What one lane found for the current scan
    typedef struct packed {
        logic             on;
        logic             off;
        logic [VEL_W-1:0] vel;
    } vkms_lane_res_t;

    // 12 * octave, modulo 256, for octaves -3 to 3
    function automatic logic [NOTE_W-1:0] oct_offset(input logic signed [2:0] oct);
        logic [NOTE_W-1:0] off;
        case (oct)
            3'b000:  off = 8'd0;
            3'b001:  off = 8'd12;
            3'b010:  off = 8'd24;
            3'b011:  off = 8'd36;
            3'b111:  off = 8'd244;
            3'b110:  off = 8'd232;
            3'b101:  off = 8'd220;
            default: off = 8'd0;
        endcase
        return off;
    endfunction

endpackage

FILE: sv/velocity_key_matrix_scanner_core.sv
// Dual-contact key matrix scanner with velocity. One lane per row pair
// handles all columns of that pair, so a column scan updates every key of
// the column in the cycle it is accepted. A button item (op 1) or a scan of
// a column at or above COLUMN_LINES leaves the block idle, and the next
// request is taken in the following cycle. A scan of a valid column is
// accepted, then runs the velocity units (scale, seven quotient steps of
// the divide by the time window, square, cube), then sends one message per
// cycle while the output is not stalled and returns to idle; up to
// 2 * (ROW_LINES / 2) messages per scan. Messages are note-ons in pair
// order, then note-offs, with last marking the final one. Key flags clear
// at reset, no sweep is needed. Configuration must be written only while
// no scan is in progress; the user is bound, the block does not enforce it.
module velocity_key_matrix_scanner_core #(
    parameter int ROW_LINES    = 16,
    parameter int COLUMN_LINES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [2:0]  column,
    input  logic [15:0] row_levels,
    input  logic [31:0] now_us,
    input  logic        minus_level,
    input  logic        plus_level,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  status_byte,
    output logic [7:0]  note_number,
    output logic [6:0]  velocity,
    output logic        last
);
    import vkms_pkg::*;

    localparam int PAIR_COUNT = ROW_LINES / 2;
    localparam int COL_W      = (COLUMN_LINES > 1) ? $clog2(COLUMN_LINES) : 1;
    localparam logic [4:0] COL_LIMIT = 5'(COLUMN_LINES);

    // Sequencer steps after acceptance
    localparam logic [3:0] STEP_MUL       = 4'd0;
    localparam logic [3:0] STEP_DIV_FIRST = 4'd1;
    localparam logic [3:0] STEP_DIV_LAST  = 4'd7;
    localparam logic [3:0] STEP_SQ        = 4'd8;
    localparam logic [3:0] STEP_CUBE      = 4'd9;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [3:0]            step_reg;
    logic [DIV_W-1:0]      div_reg;
    logic [COL_W-1:0]      col_reg;
    logic [TIME_W-1:0]     fast_gap_reg, slow_gap_reg;
    logic [6:0]            base_note_reg;
    logic signed [2:0]     octave_reg, octave_next, octave_mid;
    logic [1:0]            buttons_reg;

    logic                  in_accept, col_ok, scan_go, button_go, merge_load, merge_busy;
    logic [COL_W-1:0]      col_idx;
    logic [TIME_W-1:0]     span;
    vkms_ctrl_t            ctrl;
    vkms_lane_res_t [PAIR_COUNT-1:0] lane_res;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign col_ok    = ({2'b00, column} < COL_LIMIT);
    assign scan_go   = in_accept && (op == OP_SCAN) && col_ok;
    assign button_go = in_accept && (op == OP_BUTTON);
    assign col_idx   = COL_W'(column);
    assign span      = slow_gap_reg - fast_gap_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_gap_reg  <= 20'd1000;
            slow_gap_reg  <= 20'd50000;
            base_note_reg <= 7'd36;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FAST_GAP:  fast_gap_reg  <= cfg_data;
                REG_SLOW_GAP:  slow_gap_reg  <= cfg_data;
                REG_BASE_NOTE: base_note_reg <= cfg_data[6:0];
                default:       ;
            endcase
        end
    end

    // Octave buttons: minus edge first, then plus edge
    always_comb
    begin
        octave_mid  = octave_reg;
        if (minus_level && !buttons_reg[0] && octave_reg > OCT_LOW)
            octave_mid = octave_reg - 3'sd1;
        octave_next = octave_mid;
        if (plus_level && !buttons_reg[1] && octave_mid < OCT_HIGH)
            octave_next = octave_mid + 3'sd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_reg  <= '0;
            buttons_reg <= '0;
        end
        else if (button_go)
        begin
            octave_reg  <= octave_next;
            buttons_reg <= {plus_level, minus_level};
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        merge_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (scan_go)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (step_reg == STEP_CUBE)
                begin
                    state_next = ST_EMIT;
                    merge_load = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!merge_busy)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CALC)
                step_reg <= step_reg + 4'd1;
            else
                step_reg <= '0;
        end
    end

    // Divisor walks down one bit per quotient step
    always_ff @(posedge clk)
    begin
        if (scan_go)
        begin
            div_reg <= {span, 6'd0};
            col_reg <= col_idx;
        end
        else if (ctrl.div_en)
        begin
            div_reg <= div_reg >> 1;
        end
    end

    // Lane control
    always_comb
    begin
        ctrl.load       = scan_go;
        ctrl.mul_en     = (state_reg == ST_CALC) && (step_reg == STEP_MUL);
        ctrl.div_en     = (state_reg == ST_CALC) &&
                          (step_reg inside {[STEP_DIV_FIRST:STEP_DIV_LAST]});
        ctrl.sq_en      = (state_reg == ST_CALC) && (step_reg == STEP_SQ);
        ctrl.cube_en    = (state_reg == ST_CALC) && (step_reg == STEP_CUBE);
        ctrl.bad_window = (slow_gap_reg <= fast_gap_reg);
        ctrl.fast_gap   = fast_gap_reg;
        ctrl.slow_gap   = slow_gap_reg;
        ctrl.divisor    = div_reg;
    end

    // One lane per row pair; rows past the port read as open
    for (genvar p = 0; p < PAIR_COUNT; p++)
    begin : g_lane
        logic odd_level, even_level;

        if (2 * p + 1 < ROW_PORT_W)
        begin : g_both
            assign odd_level  = row_levels[2*p+1];
            assign even_level = row_levels[2*p];
        end
        else
        begin : g_open
            assign odd_level  = 1'b0;
            assign even_level = 1'b0;
        end

        vkms_lane #(
            .COLUMN_LINES (COLUMN_LINES)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .col_idx    (col_idx),
            .odd_level  (odd_level),
            .even_level (even_level),
            .now_us     (now_us),
            .res        (lane_res[p])
        );
    end

    vkms_merge #(
        .PAIR_COUNT   (PAIR_COUNT),
        .COLUMN_LINES (COLUMN_LINES)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (merge_load),
        .res         (lane_res),
        .col         (col_reg),
        .base_note   (base_note_reg),
        .octave      (octave_reg),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .status_byte (status_byte),
        .note_number (note_number),
        .velocity    (velocity),
        .last        (last),
        .busy        (merge_busy)
    );

endmodule

FILE: sv/vkms_lane.sv
// One row pair: key flags and press stamps for every column, plus a
// velocity unit (clamp, 7-step quotient, cubic curve).
module vkms_lane #(
    parameter int COLUMN_LINES = 8,
    localparam int COL_W = (COLUMN_LINES > 1) ? $clog2(COLUMN_LINES) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  vkms_pkg::vkms_ctrl_t    ctrl,
    input  logic [COL_W-1:0]        col_idx,
    input  logic                    odd_level,
    input  logic                    even_level,
    input  logic [31:0]             now_us,
    output vkms_pkg::vkms_lane_res_t res
);
    import vkms_pkg::*;

    logic [COLUMN_LINES-1:0] key_down_reg;
    logic [COLUMN_LINES-1:0] pend_reg;
    logic [STAMP_W-1:0]      stamp_reg [COLUMN_LINES];

    logic               on_reg, off_reg;
    logic [STAMP_W-1:0] elapsed_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [VEL_W-1:0]   quo_reg;
    logic [VEL_W-1:0]   v_reg;
    logic [VEL_W-1:0]   vv_reg;
    logic [VEL_W-1:0]   vel_reg;

    logic               kd, pend, press, pend_hit, on_next, off_next, pend_next;
    logic [STAMP_W-1:0] stamp_cur, elapsed_next;
    logic [STAMP_W-1:0] t_hi, t_clamp;
    logic [TIME_W-1:0]  span_n;
    logic [REM_W:0]     trial;
    logic [VEL_W-1:0]   v_next;
    logic [2*VEL_W-1:0] sq_prod, cube_prod;

    // Press / note-on / release decision for the driven column
    always_comb
    begin
        kd           = key_down_reg[col_idx];
        pend         = pend_reg[col_idx];
        press        = odd_level && !kd;
        pend_hit     = press || pend;
        stamp_cur    = press ? now_us : stamp_reg[col_idx];
        on_next      = even_level && pend_hit;
        off_next     = !odd_level && kd;
        pend_next    = pend_hit && !on_next;
        elapsed_next = now_us - stamp_cur;
    end

    // Key flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_down_reg <= '0;
            pend_reg     <= '0;
            on_reg       <= 1'b0;
            off_reg      <= 1'b0;
        end
        else if (ctrl.load)
        begin
            key_down_reg[col_idx] <= odd_level;
            pend_reg[col_idx]     <= pend_next;
            on_reg                <= on_next;
            off_reg               <= off_next;
        end
    end

    // Press stamps, only read while the pending flag is set
    always_ff @(posedge clk)
    begin
        if (ctrl.load && press)
            stamp_reg[col_idx] <= now_us;
    end

    // Velocity datapath
    always_comb
    begin
        t_hi      = (elapsed_reg > {12'd0, ctrl.slow_gap}) ? {12'd0, ctrl.slow_gap}
                                                           : elapsed_reg;
        t_clamp   = (t_hi < {12'd0, ctrl.fast_gap}) ? {12'd0, ctrl.fast_gap} : t_hi;
        span_n    = t_clamp[TIME_W-1:0] - ctrl.fast_gap;
        trial     = {1'b0, rem_reg} - {2'b00, ctrl.divisor};
        v_next    = FULL_VELOCITY - quo_reg;
        sq_prod   = v_next * v_next;
        cube_prod = vv_reg * v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            elapsed_reg <= elapsed_next;
        // scaled gap: n * 127
        if (ctrl.mul_en)
        begin
            rem_reg <= {span_n, 7'd0} - {7'd0, span_n};
            quo_reg <= '0;
        end
        // one quotient bit per step, MSB first
        if (ctrl.div_en)
        begin
            if (!trial[REM_W])
            begin
                rem_reg <= trial[REM_W-1:0];
                quo_reg <= {quo_reg[VEL_W-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[VEL_W-2:0], 1'b0};
            end
        end
        if (ctrl.sq_en)
        begin
            v_reg  <= v_next;
            vv_reg <= sq_prod[2*VEL_W-1:VEL_W];
        end
        if (ctrl.cube_en)
        begin
            if (ctrl.bad_window || v_reg == FULL_VELOCITY)
                vel_reg <= FULL_VELOCITY;
            else
                vel_reg <= cube_prod[2*VEL_W-1:VEL_W];
        end
    end

    assign res.on  = on_reg;
    assign res.off = off_reg;
    assign res.vel = vel_reg;

endmodule

FILE: sv/vkms_merge.sv
// Merging stage: note-ons in pair order, then note-offs, into one
// output register.
module vkms_merge #(
    parameter int PAIR_COUNT   = 8,
    parameter int COLUMN_LINES = 8,
    localparam int PW    = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1,
    localparam int COL_W = (COLUMN_LINES > 1) ? $clog2(COLUMN_LINES) : 1
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     load,
    input  vkms_pkg::vkms_lane_res_t [PAIR_COUNT-1:0] res,
    input  logic [COL_W-1:0]                         col,
    input  logic [6:0]                               base_note,
    input  logic signed [2:0]                        octave,
    input  logic                                     out_stall,
    output logic                                     out_valid,
    output logic [7:0]                               status_byte,
    output logic [7:0]                               note_number,
    output logic [6:0]                               velocity,
    output logic                                     last,
    output logic                                     busy
);
    import vkms_pkg::*;

    logic [PAIR_COUNT-1:0] on_left_reg, off_left_reg;
    logic [PAIR_COUNT-1:0] on_hits, off_hits, pick, rest;
    logic                  out_valid_reg, last_reg;
    logic [7:0]            status_reg, note_reg;
    logic [VEL_W-1:0]      vel_reg;

    logic                  slot_free, use_on, emit, last_next;
    logic [PW-1:0]         pick_idx;
    logic [NOTE_W-1:0]     key_num, note_next;

    // lowest set bit wins
    function automatic logic [PW-1:0] first_set(input logic [PAIR_COUNT-1:0] flags);
        logic [PW-1:0] idx;
        idx = '0;
        for (int i = PAIR_COUNT - 1; i >= 0; i--)
        begin
            if (flags[i])
                idx = PW'(i);
        end
        return idx;
    endfunction

    always_comb
    begin
        for (int i = 0; i < PAIR_COUNT; i++)
        begin
            on_hits[i]  = res[i].on;
            off_hits[i] = res[i].off;
        end
    end

    // Pick the next message
    always_comb
    begin
        slot_free = !out_valid_reg || !out_stall;
        use_on    = |on_left_reg;
        pick      = use_on ? on_left_reg : off_left_reg;
        pick_idx  = first_set(pick);
        rest      = pick & (pick - PAIR_COUNT'(1));
        emit      = slot_free && (|pick);
        last_next = use_on ? ((rest == '0) && (off_left_reg == '0)) : (rest == '0);
        key_num   = 8'(32'(pick_idx) * COLUMN_LINES) + 8'(col);
        note_next = {1'b0, base_note} + key_num + oct_offset(octave);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_left_reg   <= '0;
            off_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                on_left_reg  <= on_hits;
                off_left_reg <= off_hits;
            end
            else if (emit)
            begin
                if (use_on)
                    on_left_reg <= rest;
                else
                    off_left_reg <= rest;
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg <= use_on ? STATUS_NOTE_ON : STATUS_NOTE_OFF;
            note_reg   <= note_next;
            vel_reg    <= use_on ? res[pick_idx].vel : '0;
            last_reg   <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status_byte = status_reg;
    assign note_number = note_reg;
    assign velocity    = vel_reg;
    assign last        = last_reg;
    assign busy        = (|on_left_reg) || (|off_left_reg);

endmodule

FILE: sv/vkms_checker.sv
`include "velocity_key_matrix_scanner_core_macros.svh"

// Port-level checks for the scanner
module vkms_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        op,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  status_byte,
    input logic [6:0]  velocity,
    input logic [7:0]  note_number,
    input logic        last
);
    import vkms_pkg::*;

    // A held message keeps its payload
    `VKMS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status_byte) && $stable(note_number) && $stable(velocity) && $stable(last), "stalled message changed")

    // Only note-on and note-off leave the block
    `VKMS_ASSERT_NOW(a_status_code, out_valid, status_byte == STATUS_NOTE_ON || status_byte == STATUS_NOTE_OFF, "unknown status")

    // Note-off carries zero velocity
    `VKMS_ASSERT_NOW(a_off_vel, out_valid && status_byte == STATUS_NOTE_OFF, velocity == 7'd0, "note-off with velocity")

    // A button request does not hold up the next request
    `VKMS_ASSERT_NEXT(a_button_quick, in_valid && !in_stall && op == OP_BUTTON, !in_stall, "button request held input")

endmodule

bind velocity_key_matrix_scanner_core vkms_checker u_vkms_checker (.*);

FILE: dv/tb_velocity_key_matrix_scanner_core.sv
`timescale 1ns / 1ps

module tb_velocity_key_matrix_scanner_core;
    import vkms_pkg::*;

    localparam int PAIRS = 8;
    localparam int COLS = 8;
    localparam int KEYS = PAIRS * COLS;
    localparam int RUN_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 40;

    // One scan or button request as offered to the block
    typedef struct packed {
        logic        op;
        logic [2:0]  column;
        logic [15:0] rows;
        logic [31:0] now;
        logic        minus;
        logic        plus;
    } key_request_t;

    // One MIDI message as produced by the block
    typedef struct packed {
        logic [7:0] status;
        logic [7:0] note;
        logic [6:0] vel;
        logic       last;
    } midi_msg_t;

    // Keyboard state mirror plus the queue of messages still owed by the block
    class note_ledger;
        logic [19:0] min_us;
        logic [19:0] max_us;
        logic [6:0]  base;
        bit          held[KEYS];
        logic [31:0] stamp[KEYS];
        bit          armed[KEYS];
        int          octave;
        logic [1:0]  buttons;
        midi_msg_t   owed[$];
        int          errors;

        function new();
            min_us = 20'd1000;
            max_us = 20'd50000;
            base = 7'd36;
            octave = 0;
            buttons = 2'b00;
            errors = 0;
            foreach (held[k])
            begin
                held[k] = 1'b0;
                stamp[k] = '0;
                armed[k] = 1'b0;
            end
        endfunction

        function void set_register(logic [1:0] idx, logic [19:0] data);
            case (idx)
                REG_FAST_GAP:  min_us = data;
                REG_SLOW_GAP:  max_us = data;
                REG_BASE_NOTE: base = data[6:0];
                default: ;
            endcase
        endfunction

        // Clamp the contact gap, map it linearly, then apply the cubic curve
        function logic [6:0] curve(logic [31:0] elapsed);
            longint unsigned t;
            longint unsigned v;
            if (max_us <= min_us)
                return FULL_VELOCITY;
            t = elapsed;
            if (t > max_us)
                t = max_us;
            if (t < min_us)
                t = min_us;
            v = 127 - ((t - min_us) * 127) / (max_us - min_us);
            if (v < 127)
                v = (((v * v) >> 7) * v) >> 7;
            return v[6:0];
        endfunction

        function logic [7:0] note_of(int key);
            int n;
            n = int'(base) + key + 12 * octave;
            return n[7:0];
        endfunction

        function void note_request(key_request_t r);
            int        key;
            int        first;
            midi_msg_t m;
            if (r.op == OP_BUTTON)
            begin
                // minus edge first, then plus edge, both saturating
                if (r.minus && !buttons[0] && octave > OCT_LOW)
                    octave--;
                if (r.plus && !buttons[1] && octave < OCT_HIGH)
                    octave++;
                buttons = {r.plus, r.minus};
                return;
            end
            // every 3-bit column is below COLS, so no scan is dropped here
            first = owed.size();
            // presses and note-ons, pair 0 upward
            for (int p = 0; p < PAIRS; p++)
            begin
                key = p * COLS + r.column;
                if (r.rows[2 * p + 1] && !held[key])
                begin
                    held[key] = 1'b1;
                    stamp[key] = r.now;
                    armed[key] = 1'b1;
                end
                if (r.rows[2 * p] && armed[key])
                begin
                    owed.push_back({STATUS_NOTE_ON, note_of(key),
                                    curve(r.now - stamp[key]), 1'b0});
                    stamp[key] = '0;
                    armed[key] = 1'b0;
                end
            end
            // releases, pair 0 upward
            for (int p = 0; p < PAIRS; p++)
            begin
                key = p * COLS + r.column;
                if (!r.rows[2 * p + 1] && held[key])
                begin
                    held[key] = 1'b0;
                    owed.push_back({STATUS_NOTE_OFF, note_of(key), 7'd0, 1'b0});
                end
            end
            if (owed.size() > first)
            begin
                m = owed.pop_back();
                m.last = 1'b1;
                owed.push_back(m);
            end
        endfunction

        function void check_message(midi_msg_t got);
            midi_msg_t want;
            if (owed.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected message: status %0d note %0d vel %0d last %0b",
                             got.status, got.note, got.vel, got.last);
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status || got.note !== want.note ||
                got.vel !== want.vel || got.last !== want.last)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("message mismatch: expected status %0d note %0d vel %0d last %0b",
                             want.status, want.note, want.vel, want.last);
                    $display("  got status %0d note %0d vel %0d last %0b",
                             got.status, got.note, got.vel, got.last);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_FAST_GAP;
    logic [19:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = OP_SCAN;
    logic [2:0]  column = '0;
    logic [15:0] row_levels = '0;
    logic [31:0] now_us = '0;
    logic        minus_level = 1'b0;
    logic        plus_level = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  status_byte;
    logic [7:0]  note_number;
    logic [6:0]  velocity;
    logic        last;

    note_ledger  ledger = new();

    bit          send_gaps = 1'b1;
    bit          sink_gaps = 1'b1;
    int          hold_left = 0;
    int          sink_burst = 0;
    int          cycle_count = 0;
    logic [31:0] clock_us = 32'd200000;
    bit          btn_minus = 1'b0;
    bit          btn_plus = 1'b0;
    // 0 open, 1 first contact, 2 both contacts, 3 second contact only
    int          contact[KEYS];

    velocity_key_matrix_scanner_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .column      (column),
        .row_levels  (row_levels),
        .now_us      (now_us),
        .minus_level (minus_level),
        .plus_level  (plus_level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status_byte (status_byte),
        .note_number (note_number),
        .velocity    (velocity),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > RUN_LIMIT)
            begin
                $display("velocity_key_matrix_scanner_core verification failed");
                $finish;
            end
        end
    end

    // Message sink: check on accept, then pick the stall for the next cycle
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                ledger.check_message({status_byte, note_number, velocity, last});
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (sink_burst > 0)
            begin
                out_stall <= 1'b1;
                sink_burst--;
            end
            else if (sink_gaps && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                sink_burst = $urandom_range(0, 7);
            end
            else
                out_stall <= 1'b0;
        end
    end

    function automatic key_request_t scan_of(logic [2:0] col, logic [15:0] rows,
                                             logic [31:0] stamp_us);
        return {OP_SCAN, col, rows, stamp_us, 1'b0, 1'b0};
    endfunction

    // Scan fields are junk on a button request and must be ignored
    function automatic key_request_t button_of(logic minus, logic plus);
        return {OP_BUTTON, 3'($urandom), 16'($urandom), 32'($urandom), minus, plus};
    endfunction

    // Offer one request and hold it until accepted
    task automatic drive_request(key_request_t r);
        if (send_gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= r.op;
        column <= r.column;
        row_levels <= r.rows;
        now_us <= r.now;
        minus_level <= r.minus;
        plus_level <= r.plus;
        do
            @(posedge clk);
        while (in_stall);
        ledger.note_request(r);
    endtask

    // Stop sending and wait until all owed messages are in and the block is quiet
    task automatic settle_block();
        in_valid <= 1'b0;
        while (ledger.owed.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timing(logic [19:0] lo, logic [19:0] hi, logic [6:0] note);
        cfg_we <= 1'b1;
        cfg_index <= REG_FAST_GAP;
        cfg_data <= lo;
        @(posedge clk);
        ledger.set_register(REG_FAST_GAP, lo);
        cfg_index <= REG_SLOW_GAP;
        cfg_data <= hi;
        @(posedge clk);
        ledger.set_register(REG_SLOW_GAP, hi);
        cfg_index <= REG_BASE_NOTE;
        cfg_data <= {13'd0, note};
        @(posedge clk);
        ledger.set_register(REG_BASE_NOTE, {13'd0, note});
        cfg_we <= 1'b0;
    endtask

    // Mostly realistic key strokes, some octave button presses, some row noise
    task automatic play_phase(int count, int step_max, bit octave_up);
        key_request_t r;
        int           kind;
        int           key;
        int           roll;
        logic [2:0]   col;
        logic [15:0]  rows;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 12)
            begin
                if (octave_up)
                begin
                    btn_plus = !btn_plus;
                    btn_minus = ($urandom_range(0, 7) == 0);
                end
                else
                begin
                    btn_minus = !btn_minus;
                    btn_plus = ($urandom_range(0, 7) == 0);
                end
                r = button_of(btn_minus, btn_plus);
            end
            else if (kind < 18)
                r = scan_of(3'($urandom), 16'($urandom), 32'($urandom));
            else
            begin
                col = 3'($urandom_range(0, COLS - 1));
                clock_us += $urandom_range(0, step_max);
                rows = '0;
                for (int p = 0; p < PAIRS; p++)
                begin
                    key = p * COLS + col;
                    roll = $urandom_range(0, 99);
                    case (contact[key])
                        0: if (roll < 35) contact[key] = 1;
                           else if (roll < 40) contact[key] = 2;
                        1: if (roll < 40) contact[key] = 2;
                           else if (roll < 55) contact[key] = 0;
                        2: if (roll < 30) contact[key] = 0;
                           else if (roll < 40) contact[key] = 1;
                           else if (roll < 45) contact[key] = 3;
                        default: if (roll < 50) contact[key] = 0;
                                 else contact[key] = 2;
                    endcase
                    rows[2 * p + 1] = (contact[key] == 1 || contact[key] == 2);
                    rows[2 * p] = (contact[key] == 2 || contact[key] == 3);
                end
                r = scan_of(col, rows, clock_us);
            end
            drive_request(r);
        end
    endtask

    initial
    begin
        foreach (contact[k])
            contact[k] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full columns, longest scan, octave buttons, time wrap
        drive_request(scan_of(3'd0, 16'hAAAA, 32'd0));
        drive_request(scan_of(3'd0, 16'hFFFF, 32'd0));
        drive_request(scan_of(3'd0, 16'h0000, 32'd10));
        // press and note-on in the same scan
        drive_request(scan_of(3'd7, 16'hFFFF, 32'd25500));
        // eight note-ons and eight note-offs from one scan
        drive_request(scan_of(3'd3, 16'hAAAA, 32'd100));
        drive_request(scan_of(3'd3, 16'h5555, 32'd26100));
        drive_request(scan_of(3'd7, 16'h0000, 32'd26200));
        // both buttons rise together: down then up
        drive_request(button_of(1'b1, 1'b1));
        drive_request(button_of(1'b0, 1'b0));
        drive_request(button_of(1'b1, 1'b0));
        // gap beyond the window gives zero velocity, one octave down
        drive_request(scan_of(3'd1, 16'h0002, 32'd1000));
        drive_request(scan_of(3'd1, 16'h0003, 32'd52000));
        drive_request(scan_of(3'd1, 16'h0000, 32'd52100));
        drive_request(button_of(1'b0, 1'b1));
        drive_request(button_of(1'b0, 1'b0));
        // press just before the timer wraps, velocity after it
        drive_request(scan_of(3'd2, 16'h8000, 32'hFFFF_FF00));
        drive_request(scan_of(3'd2, 16'hC000, 32'h0000_0200));
        drive_request(scan_of(3'd2, 16'h4000, 32'hFFFF_FFFF));
        // second contact with no press pending does nothing
        drive_request(scan_of(3'd5, 16'h0001, 32'd5));
        drive_request(scan_of(3'd5, 16'h0002, 32'd30000));
        drive_request(scan_of(3'd5, 16'h0002, 32'd31000));
        drive_request(scan_of(3'd5, 16'h0001, 32'd32000));

        // Reset timing, with a long sink hold in the middle
        play_phase(30, 3000, 1'b1);
        hold_left = 300;
        play_phase(30, 3000, 1'b1);
        settle_block();

        // Widest window, top base note
        write_timing(20'd0, 20'd1000000, 7'd127);
        play_phase(55, 40000, 1'b0);
        settle_block();

        // Inverted window forces full velocity
        write_timing(20'd1000000, 20'd1, 7'd0);
        sink_gaps = 1'b0;
        play_phase(45, 3000, 1'b0);
        settle_block();

        // Empty window, sender without gaps
        write_timing(20'd5000, 20'd5000, 7'd100);
        sink_gaps = 1'b1;
        send_gaps = 1'b0;
        play_phase(40, 3000, 1'b1);
        settle_block();

        // Narrow window across the timer wrap, no idling at all
        write_timing(20'd500, 20'd20000, 7'd36);
        sink_gaps = 1'b0;
        clock_us = 32'hFFFF_0000;
        play_phase(90, 2500, 1'b1);
        settle_block();

        if (ledger.errors == 0 && ledger.owed.size() == 0)
            $display("velocity_key_matrix_scanner_core verification clean");
        else
            $display("velocity_key_matrix_scanner_core verification failed");
        $finish;
    end

endmodule

FILE: velocity_key_matrix_scanner_core.f
+incdir+sv
sv/vkms_pkg.sv
sv/vkms_lane.sv
sv/vkms_merge.sv
sv/velocity_key_matrix_scanner_core.sv
sv/vkms_checker.sv
dv/tb_velocity_key_matrix_scanner_core.sv
